// ===== src/mbe_pkg.sv =====
// Shared types, constants and helpers for the escape-time pixel core.
// No dependencies; every other file in src imports this package.
package mbe_pkg;

   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int LIMIT_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int FIX_W      = 32;
   localparam int DIV_W      = 50;
   localparam int DIVISOR_W  = 13;
   localparam int DIV_CNT_W  = 6;
   localparam int WIDE_W     = 52;
   localparam int MAX_DIMENSION = 4096;

   // |z|^2 escape bound, 4.0 on Q8.56 squared magnitudes
   localparam logic [63:0] ESCAPE = 64'h0400_0000_0000_0000;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_ITER_LIMIT   = 3'd2,
      REG_ZOOM_SCALE   = 3'd3,
      REG_OFFSET_X     = 3'd4,
      REG_OFFSET_Y     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0]     col;
      logic [COORD_W-1:0]     row;
      logic signed [FIX_W-1:0] cr;
      logic signed [FIX_W-1:0] ci;
   } pix_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MUL, F_SUM, F_DIV, F_WAIT, F_FIX, F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_SQ, B_CHK, B_GRAY, B_DIVW, B_OUT
   } back_state_type;

   // Saturate a wide signed value to signed 32 bit.
   function automatic logic signed [FIX_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32'sh7FFF_FFFF);
      lo = -hi - WIDE_W'(1);
      if (v > hi) return 32'sh7FFF_FFFF;
      else if (v < lo) return 32'sh8000_0000;
      else return v[FIX_W-1:0];
   endfunction

   // Zero and oversize dimensions map to 1 and MAX_DIMENSION.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] n);
      if (n == '0) return DIM_W'(1);
      else if (n > DIM_W'(MAX_DIMENSION)) return DIM_W'(MAX_DIMENSION);
      else return n;
   endfunction

endpackage

// ===== src/mbe_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mbe_pkg for widths and the request struct.
module mbe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  mbe_pkg::div_req_type        req,
   output logic                        done,
   output logic [mbe_pkg::DIV_W-1:0]   quotient
);
   import mbe_pkg::*;

   logic [DIVISOR_W:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff[DIVISOR_W-1:0], quo_ff[DIV_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         dsr_in = req.divisor;
         cnt_in = DIV_CNT_W'(DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial - {1'b0, dsr_ff} : trial;
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/mbe_front.sv =====
// Front end: accepts a pixel, maps column and row to a Q4.28 point.
// Depends on mbe_pkg and mbe_div (shared by both axes).
module mbe_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,
   input  logic [mbe_pkg::DIM_W-1:0]    image_width,
   input  logic [mbe_pkg::DIM_W-1:0]    image_height,
   input  logic [mbe_pkg::FIX_W-1:0]    zoom_scale,
   input  logic signed [mbe_pkg::FIX_W-1:0] offset_x,
   input  logic signed [mbe_pkg::FIX_W-1:0] offset_y,
   output logic                         push,
   output mbe_pkg::pix_type             push_data,
   input  logic                         full
);
   import mbe_pkg::*;

   front_state_type state_ff, state_in;
   logic [COORD_W-1:0]       col_ff, col_in, row_ff, row_in;
   logic                     ax_ff, ax_in;
   logic signed [45:0]       prod_ff, prod_in;
   logic signed [50:0]       num_ff, num_in;
   logic signed [WIDE_W-1:0] q_ff, q_in;
   logic signed [FIX_W-1:0]  cr_ff, cr_in, ci_ff, ci_in;
   div_req_type              dreq;
   logic                     ddone;
   logic [DIV_W-1:0]         dquo;
   logic [COORD_W-1:0]       p_sel;
   logic [DIM_W-1:0]         n_sel;
   logic signed [FIX_W-1:0]  off_sel;
   logic signed [DIM_W:0]    d;
   logic signed [50:0]       mag;
   logic signed [FIX_W-1:0]  res;
   logic signed [WIDE_W-1:0] shift;

   mbe_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quotient(dquo));

   always_comb begin
      p_sel   = ax_ff ? row_ff : col_ff;
      n_sel   = clamp_dim(ax_ff ? image_height : image_width);
      off_sel = ax_ff ? offset_y : offset_x;
      d       = signed'({2'b0, p_sel}) - signed'({2'b0, n_sel[DIM_W-1:1]});
      shift   = ax_ff ? (WIDE_W'(1) <<< 27) : (WIDE_W'(3) <<< 27);
      mag     = num_ff[50] ? -num_ff : num_ff;
      res     = sat32(q_ff - shift);

      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      ax_in  = ax_ff;
      prod_in = prod_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      cr_in   = cr_ff;
      ci_in   = ci_ff;
      dreq.start    = 1'b0;
      dreq.dividend = mag[DIV_W-1:0];
      dreq.divisor  = n_sel;
      push = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         F_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               col_in = req_tdata[11:0];
               row_in = req_tdata[23:12];
               ax_in  = 1'b0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in  = 46'(d) * 46'(signed'({1'b0, zoom_scale}));
            state_in = F_SUM;
         end
         F_SUM: begin
            num_in   = (51'(prod_ff) <<< 4) + (51'(off_sel) <<< 12);
            state_in = F_DIV;
         end
         F_DIV: begin
            dreq.start = 1'b1;
            state_in   = F_WAIT;
         end
         F_WAIT: begin
            if (ddone) begin
               q_in = num_ff[50] ? -signed'({2'b0, dquo}) : signed'({2'b0, dquo});
               state_in = F_FIX;
            end
         end
         F_FIX: begin
            if (ax_ff) begin
               ci_in    = res;
               state_in = F_PUSH;
            end else begin
               cr_in    = res;
               ax_in    = 1'b1;
               state_in = F_MUL;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase

      push_data.col = col_ff;
      push_data.row = row_ff;
      push_data.cr  = cr_ff;
      push_data.ci  = ci_ff;
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      ax_ff  <= ax_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== src/mbe_fifo.sv =====
// Two-entry queue of mapped pixels between front and back end.
// Depends on mbe_pkg for the entry type.
module mbe_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbe_pkg::pix_type push_data,
   output logic             full,
   input  logic             pop,
   output mbe_pkg::pix_type pop_data,
   output logic             empty
);
   import mbe_pkg::*;

   pix_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== src/mbe_back.sv =====
// Back end: escape-time iteration, gray level division, result register.
// Depends on mbe_pkg and mbe_div.
module mbe_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   output logic                          pop,
   input  mbe_pkg::pix_type              pop_data,
   input  logic [mbe_pkg::LIMIT_W-1:0]   iteration_limit,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata
);
   import mbe_pkg::*;

   back_state_type state_ff, state_in;
   logic [COORD_W-1:0]       col_ff, col_in, row_ff, row_in;
   logic signed [FIX_W-1:0]  cr_ff, cr_in, ci_ff, ci_in;
   logic signed [FIX_W-1:0]  zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0]       rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic [7:0]               gray_ff, gray_in;
   logic [31:0]              out_ff, out_in;
   logic                     ov_ff, ov_in;
   logic [63:0]              mag;
   logic [20:0]              scaled;
   div_req_type              dreq;
   logic                     ddone;
   logic [DIV_W-1:0]         dquo;

   mbe_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quotient(dquo));

   always_comb begin
      mag    = 64'(rr_ff) + 64'(ii_ff);
      scaled = {cnt_ff, 8'b0} - 21'(cnt_ff);

      state_in = state_ff;
      col_in = col_ff; row_in = row_ff;
      cr_in = cr_ff; ci_in = ci_ff;
      zr_in = zr_ff; zi_in = zi_ff;
      rr_in = rr_ff; ii_in = ii_ff; ri_in = ri_ff;
      cnt_in = cnt_ff;
      gray_in = gray_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      pop = 1'b0;
      dreq.start    = 1'b0;
      dreq.dividend = DIV_W'(scaled);
      dreq.divisor  = DIVISOR_W'(iteration_limit);

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               col_in = pop_data.col;
               row_in = pop_data.row;
               cr_in  = pop_data.cr;
               ci_in  = pop_data.ci;
               zr_in  = '0;
               zi_in  = '0;
               cnt_in = '0;
               state_in = B_SQ;
            end
         end
         B_SQ: begin
            rr_in = 64'(zr_ff) * 64'(zr_ff);
            ii_in = 64'(zi_ff) * 64'(zi_ff);
            ri_in = 64'(zr_ff) * 64'(zi_ff);
            state_in = B_CHK;
         end
         B_CHK: begin
            if (mag >= ESCAPE) begin
               state_in = B_GRAY;
            end else begin
               cnt_in = cnt_ff + COUNT_W'(1);
               if (cnt_ff > COUNT_W'(iteration_limit)) begin
                  state_in = B_GRAY;
               end else begin
                  zr_in = sat32(WIDE_W'(rr_ff >>> 28) - WIDE_W'(ii_ff >>> 28)
                                + WIDE_W'(cr_ff));
                  zi_in = sat32(WIDE_W'(ri_ff >>> 27) + WIDE_W'(ci_ff));
                  state_in = B_SQ;
               end
            end
         end
         B_GRAY: begin
            if (cnt_ff < COUNT_W'(iteration_limit)) begin
               dreq.start = 1'b1;
               state_in   = B_DIVW;
            end else begin
               gray_in  = '0;
               state_in = B_OUT;
            end
         end
         B_DIVW: begin
            if (ddone) begin
               gray_in  = dquo[7:0];
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!ov_ff) begin
               out_in   = {gray_ff, row_ff, col_ff};
               ov_in    = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in; row_ff <= row_in;
      cr_ff <= cr_in; ci_ff <= ci_in;
      zr_ff <= zr_in; zi_ff <= zi_in;
      rr_ff <= rr_in; ii_ff <= ii_in; ri_ff <= ri_in;
      cnt_ff <= cnt_in;
      gray_ff <= gray_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= B_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ===== src/mandelbrot_escape_time_pixel_core.sv =====
// Top level of the escape-time pixel core: registers, front, queue, back.
// Depends on mbe_pkg, mbe_div, mbe_front, mbe_fifo and mbe_back.
//
// Usage:
//  - req channel: one pixel (column, row) per transaction. req_tready is high
//    while the front end is free; mapping a pixel runs the 50-step serial
//    divider once per axis.
//  - The mapped point enters a two-entry queue; the back end iterates
//    z = z*z + c, each iteration a multiply step and then an add/compare
//    step, up to limit+1 iterations plus a final escape check, then runs
//    the gray level division. The front end maps the next pixel while the
//    back end iterates, so sustained rate is set by the slower of the two.
//  - rsp channel: one transaction per pixel, in input order, from an output
//    register. A stalled receiver holds that register; the back end finishes
//    its next pixel and waits, then the queue fills and the front stalls.
//  - csr port: write only, taken on any cycle with csr_we high; write only
//    while no pixel is in flight.
//  - reset (synchronous) restores the register defaults (640x480, limit
//    255, scale 1.0, no pan) and empties both channels and the queue.
module mandelbrot_escape_time_pixel_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pixel_col[11:0], pixel_row[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_col[11:0], out_row[23:12], gray_level[31:24]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import mbe_pkg::*;

   logic [DIM_W-1:0]        width_ff, height_ff;
   logic [LIMIT_W-1:0]      limit_ff;
   logic [FIX_W-1:0]        scale_ff;
   logic signed [FIX_W-1:0] offx_ff, offy_ff;

   logic    push, full, pop, empty;
   pix_type push_data, pop_data;

   // Configuration registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         limit_ff  <= LIMIT_W'(255);
         scale_ff  <= 32'h0100_0000;
         offx_ff   <= '0;
         offy_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            REG_ITER_LIMIT:   limit_ff  <= csr_wdata[LIMIT_W-1:0];
            REG_ZOOM_SCALE:   scale_ff  <= csr_wdata;
            REG_OFFSET_X:     offx_ff   <= signed'(csr_wdata);
            REG_OFFSET_Y:     offy_ff   <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   mbe_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .image_width(width_ff), .image_height(height_ff), .zoom_scale(scale_ff),
      .offset_x(offx_ff), .offset_y(offy_ff),
      .push(push), .push_data(push_data), .full(full)
   );

   mbe_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .pop(pop), .pop_data(pop_data), .empty(empty)
   );

   mbe_back u_back (
      .clock(clock), .reset(reset),
      .empty(empty), .pop(pop), .pop_data(pop_data),
      .iteration_limit(limit_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

endmodule
